// File: rtl/core/indexed_shift_array_top_macros.svh
// Assertion macros for the indexed shift array checker.
// Included by the checker file only; depends on nothing else.
`ifndef INDEXED_SHIFT_ARRAY_TOP_MACROS_SVH
`define INDEXED_SHIFT_ARRAY_TOP_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ISA_ASSERT_CLK(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

// A condition that must never be seen outside reset.
`define ISA_ASSERT_NEVER(lbl, clk_s, rst_s, cond, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) !(cond)) else $error(msg);

`endif

// File: rtl/core/isa_pkg.sv
// Shared types and constants for the indexed shift array.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package isa_pkg;

    localparam int ISA_CAPACITY = 16;

    localparam int ISA_OP_W     = 2;
    localparam int ISA_POS_W    = 5;
    localparam int ISA_DATA_W   = 32;
    localparam int ISA_STATUS_W = 3;
    localparam int ISA_FOUND_W  = 4;
    localparam int ISA_COUNT_W  = 5;

    localparam logic [ISA_OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [ISA_OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [ISA_OP_W-1:0] OP_FIND   = 2'd2;

    localparam logic [ISA_STATUS_W-1:0] ST_OK           = 3'd0;
    localparam logic [ISA_STATUS_W-1:0] ST_BAD_POSITION = 3'd1;
    localparam logic [ISA_STATUS_W-1:0] ST_EMPTY        = 3'd2;
    localparam logic [ISA_STATUS_W-1:0] ST_FULL         = 3'd3;
    localparam logic [ISA_STATUS_W-1:0] ST_NOT_FOUND    = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic publish;
    } isa_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_find;
    } isa_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/indexed_shift_array_top.sv
// Indexed shift array: an ordered store of signed entries with insert, remove and find.
// Operation: drive op, position and value with start high; the command is taken at a
// rising edge where start is high and busy is low, and busy stays high while it runs.
// Each command gives exactly one result: status, found_position and entry_count are
// valid for the single cycle in which done is high, and the receiver must take the
// transfer then, as it cannot hold results off.
// Timing: insert and remove keep busy high through the execute state, and done is
// high as busy falls; find keeps busy high through the execute and report states,
// with done high as busy falls, because the registered match vector from all cells
// is resolved to its lowest hit in a state of its own. A new command may be issued in
// the same cycle as done, so a command is taken only once the last one is through.
// Every cell shifts and compares its own entry at once, so the time a command takes
// does not depend on the capacity.
// Reset: asynchronous, active low; clears the entry count and the controller. Entry
// contents are not cleared, since no command reads an entry at or above the count.
// Depends on isa_pkg, isa_ctrl and isa_datapath.
`timescale 1ns / 1ps
`default_nettype none

module indexed_shift_array_top
#(
    parameter int CAPACITY = isa_pkg::ISA_CAPACITY
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic [isa_pkg::ISA_OP_W-1:0]          op,
    input  wire logic [isa_pkg::ISA_POS_W-1:0]         position,
    input  wire logic signed [isa_pkg::ISA_DATA_W-1:0] value,
    output logic                                       done,
    output logic [isa_pkg::ISA_STATUS_W-1:0]           status,
    output logic [isa_pkg::ISA_FOUND_W-1:0]            found_position,
    output logic [isa_pkg::ISA_COUNT_W-1:0]            entry_count
);
    import isa_pkg::*;

    isa_cmd_t  cmd;
    isa_stat_t stat;

    isa_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    isa_datapath
    #(
        .CAPACITY (CAPACITY)
    )
    u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .op             (op),
        .position       (position),
        .value          (value),
        .stat           (stat),
        .status         (status),
        .found_position (found_position),
        .entry_count    (entry_count)
    );

endmodule

`default_nettype wire

// File: rtl/core/isa_ctrl.sv
// Sequencing state machine for the indexed shift array.
// Depends on isa_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module isa_ctrl
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire isa_pkg::isa_stat_t stat,
    output logic                  busy,
    output logic                  done,
    output isa_pkg::isa_cmd_t     cmd
);
    import isa_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_REPORT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       done_reg;

    always_comb
    begin
        cmd.capture = start && (state_reg == S_IDLE);
        cmd.exec    = (state_reg == S_EXEC);
        // A find publishes from the report state, after resolving the first match.
        cmd.publish = ((state_reg == S_EXEC) && !stat.is_find) || (state_reg == S_REPORT);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = stat.is_find ? S_REPORT : S_IDLE;
            end
            S_REPORT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.publish;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

`default_nettype wire

// File: rtl/core/isa_datapath.sv
// Entry cells, count, match vector and result registers of the indexed shift array.
// Depends on isa_pkg; driven by isa_ctrl through the command struct.
`timescale 1ns / 1ps
`default_nettype none

module isa_datapath
#(
    parameter int CAPACITY = isa_pkg::ISA_CAPACITY
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire isa_pkg::isa_cmd_t                  cmd,
    input  wire logic [isa_pkg::ISA_OP_W-1:0]       op,
    input  wire logic [isa_pkg::ISA_POS_W-1:0]      position,
    input  wire logic signed [isa_pkg::ISA_DATA_W-1:0] value,
    output isa_pkg::isa_stat_t                      stat,
    output logic [isa_pkg::ISA_STATUS_W-1:0]        status,
    output logic [isa_pkg::ISA_FOUND_W-1:0]         found_position,
    output logic [isa_pkg::ISA_COUNT_W-1:0]         entry_count
);
    import isa_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CMP_W = (CNT_W > ISA_POS_W) ? CNT_W : ISA_POS_W;
    localparam int FND_W = (IDX_W > ISA_FOUND_W) ? IDX_W : ISA_FOUND_W;
    localparam int OUT_W = (CMP_W > ISA_COUNT_W) ? CMP_W : ISA_COUNT_W;

    logic [ISA_OP_W-1:0]     op_reg;
    logic [ISA_POS_W-1:0]    pos_reg;
    logic [ISA_DATA_W-1:0]   value_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [ISA_DATA_W-1:0]   cell_reg  [CAPACITY];
    logic [ISA_DATA_W-1:0]   cell_next [CAPACITY];
    logic [CAPACITY-1:0]     hit_next;
    logic [CAPACITY-1:0]     hit_reg;
    logic [ISA_STATUS_W-1:0] status_reg;
    logic [ISA_STATUS_W-1:0] status_next;
    logic [ISA_FOUND_W-1:0]  found_reg;
    logic [ISA_FOUND_W-1:0]  found_next;
    logic [ISA_COUNT_W-1:0]  count_out_reg;
    logic [ISA_STATUS_W-1:0] exec_status;
    logic [CMP_W-1:0]        pos_ext;
    logic [CMP_W-1:0]        cnt_ext;
    logic [OUT_W-1:0]        cnt_out_ext;
    logic [FND_W-1:0]        first_idx;
    logic                    any_hit;
    logic                    do_ins;
    logic                    do_rem;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= op;
            pos_reg   <= position;
            value_reg <= value;
        end
    end

    assign stat.is_find = (op_reg == OP_FIND);
    assign pos_ext      = CMP_W'(pos_reg);
    assign cnt_ext      = CMP_W'(count_reg);

    // Legality checks: full and empty take precedence over the position.
    always_comb
    begin
        exec_status = ST_OK;
        do_ins      = 1'b0;
        do_rem      = 1'b0;
        case (op_reg)
            OP_INSERT:
            begin
                if (cnt_ext >= CMP_W'(CAPACITY))
                begin
                    exec_status = ST_FULL;
                end
                else if (pos_ext > cnt_ext)
                begin
                    exec_status = ST_BAD_POSITION;
                end
                else
                begin
                    do_ins = 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (cnt_ext == '0)
                begin
                    exec_status = ST_EMPTY;
                end
                else if (pos_ext >= cnt_ext)
                begin
                    exec_status = ST_BAD_POSITION;
                end
                else
                begin
                    do_rem = 1'b1;
                end
            end
            OP_FIND:
            begin
                exec_status = ST_OK;
            end
            default:
            begin
                exec_status = ST_BAD_POSITION;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.exec && do_ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.exec && do_rem)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Each cell picks its neighbour, the new value or itself, and compares in parallel.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam logic [CMP_W-1:0] I_EXT = CMP_W'(i);
        localparam logic [CMP_W-1:0] I_NXT = CMP_W'(i + 1);

        logic [ISA_DATA_W-1:0] from_below;
        logic [ISA_DATA_W-1:0] from_above;

        if (i > 0)
        begin : g_below
            assign from_below = cell_reg[i-1];
        end
        else
        begin : g_no_below
            assign from_below = cell_reg[i];
        end

        if (i < CAPACITY - 1)
        begin : g_above
            assign from_above = cell_reg[i+1];
        end
        else
        begin : g_no_above
            assign from_above = cell_reg[i];
        end

        always_comb
        begin
            cell_next[i] = cell_reg[i];
            if (cmd.exec && do_ins)
            begin
                if (I_EXT == pos_ext)
                begin
                    cell_next[i] = value_reg;
                end
                else if ((I_EXT > pos_ext) && (I_EXT <= cnt_ext))
                begin
                    cell_next[i] = from_below;
                end
            end
            else if (cmd.exec && do_rem)
            begin
                if ((I_EXT >= pos_ext) && (I_NXT < cnt_ext))
                begin
                    cell_next[i] = from_above;
                end
            end
        end

        assign hit_next[i] = (cell_reg[i] == value_reg) && (I_EXT < cnt_ext);

        always_ff @(posedge clk)
        begin
            cell_reg[i] <= cell_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            hit_reg <= hit_next;
        end
    end

    // Lowest set bit of the registered match vector.
    always_comb
    begin
        first_idx = '0;
        for (int k = CAPACITY - 1; k >= 0; k--)
        begin
            if (hit_reg[k])
            begin
                first_idx = FND_W'(k);
            end
        end
    end

    assign any_hit     = |hit_reg;
    assign cnt_out_ext = OUT_W'(count_next);

    always_comb
    begin
        if (stat.is_find)
        begin
            status_next = any_hit ? ST_OK : ST_NOT_FOUND;
            found_next  = any_hit ? first_idx[ISA_FOUND_W-1:0] : '0;
        end
        else
        begin
            status_next = exec_status;
            found_next  = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            status_reg    <= status_next;
            found_reg     <= found_next;
            count_out_reg <= cnt_out_ext[ISA_COUNT_W-1:0];
        end
    end

    assign status         = status_reg;
    assign found_position = found_reg;
    assign entry_count    = count_out_reg;

endmodule

`default_nettype wire

// File: rtl/core/isa_checker.sv
// Port-level checker for the indexed shift array, bound to the top level.
// Depends on isa_pkg and indexed_shift_array_top_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "indexed_shift_array_top_macros.svh"

module isa_checker
(
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               start,
    input wire logic                               busy,
    input wire logic                               done,
    input wire logic [isa_pkg::ISA_STATUS_W-1:0]   status,
    input wire logic [isa_pkg::ISA_FOUND_W-1:0]    found_position
);
    import isa_pkg::*;

    // An accepted command must hold the block busy in the next cycle.
    `ISA_ASSERT_CLK(a_accept_busy, clk, rst_n, (start && !busy) |=> busy, "accepted command did not raise busy")

    // A result transfer only happens once the command has finished.
    `ISA_ASSERT_NEVER(a_done_idle, clk, rst_n, done && busy, "result transfer while still busy")

    // A result is only published from the execute or report state, so results never come back to back.
    `ISA_ASSERT_CLK(a_done_single, clk, rst_n, done |=> !done, "result strobe held for two cycles")

    // A failed command reports no position.
    `ISA_ASSERT_NEVER(a_found_zero, clk, rst_n, done && (status != ST_OK) && (found_position != '0), "found position set on a failed command")

endmodule

bind indexed_shift_array_top isa_checker u_isa_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .status         (status),
    .found_position (found_position)
);

`default_nettype wire
